FILE: design/tcx_pkg.sv
// tcx_pkg: shared constants, opcodes and structs for the toy cpu execute unit
// no dependencies; imported by every design module

package tcx_pkg;

  localparam int DATA_W    = 16;
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 8;
  localparam int RIDX_W    = $clog2(NUM_REGS);
  localparam int OP_W      = 4;
  localparam int IMM_W     = 5;
  localparam int MOVI_W    = 9;

  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  localparam logic [OP_W-1:0] OP_LDR  = 4'd1;
  localparam logic [OP_W-1:0] OP_LDI  = 4'd2;
  localparam logic [OP_W-1:0] OP_STR  = 4'd3;
  localparam logic [OP_W-1:0] OP_STI  = 4'd4;
  localparam logic [OP_W-1:0] OP_AND  = 4'd5;
  localparam logic [OP_W-1:0] OP_OR   = 4'd6;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd7;
  localparam logic [OP_W-1:0] OP_ADDI = 4'd8;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd9;
  localparam logic [OP_W-1:0] OP_SUBI = 4'd10;
  localparam logic [OP_W-1:0] OP_MOVI = 4'd13;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    word_t             data;
  } rf_wr_t;

  typedef struct packed {
    logic              kind;
    logic [OP_W-1:0]   op;
    logic [RIDX_W-1:0] rd;
    logic [RIDX_W-1:0] rs;
    logic [RIDX_W-1:0] rt;
    logic [IMM_W-1:0]  imm;
    logic [MOVI_W-1:0] movi;
    logic [MEM_AW-1:0] pre_addr;
    word_t             pre_data;
  } dec_t;

  typedef struct packed {
    logic              reg_wr;
    logic [RIDX_W-1:0] reg_idx;
    word_t             reg_val;
    logic              mem_wr;
    logic              mem_rd;
    logic [MEM_AW-1:0] mem_addr;
    word_t             mem_data;
    logic              illegal;
  } res_t;

endpackage

FILE: design/tcx_rf.sv
// tcx_rf: register file, two banks written together, three registered read ports
// depends on tcx_pkg; entries read as zero until first written after reset

module tcx_rf import tcx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [RIDX_W-1:0] rd_s,
  input  logic [RIDX_W-1:0] rd_t,
  input  logic [RIDX_W-1:0] rd_d,
  output word_t             rdata_s,
  output word_t             rdata_t,
  output word_t             rdata_d,
  input  rf_wr_t            wr
);

  word_t                bank_st_r [NUM_REGS];
  word_t                bank_d_r  [NUM_REGS];
  logic  [NUM_REGS-1:0] vld_r;
  word_t                rdata_s_r;
  word_t                rdata_t_r;
  word_t                rdata_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_st_r[wr.idx] <= wr.data;
      bank_d_r[wr.idx]  <= wr.data;
    end
    if (rd_en) begin
      rdata_s_r <= vld_r[rd_s] ? bank_st_r[rd_s] : '0;
      rdata_t_r <= vld_r[rd_t] ? bank_st_r[rd_t] : '0;
      rdata_d_r <= vld_r[rd_d] ? bank_d_r[rd_d] : '0;
    end
  end

  assign rdata_s = rdata_s_r;
  assign rdata_t = rdata_t_r;
  assign rdata_d = rdata_d_r;

endmodule

FILE: design/tcx_dmem.sv
// tcx_dmem: word-addressed data memory, one access per cycle, registered read
// depends on tcx_pkg; contents undefined until written

module tcx_dmem import tcx_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [MEM_AW-1:0] addr,
  input  word_t             wdata,
  output word_t             rdata
);

  word_t mem_r [MEM_WORDS];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/tcx_alu.sv
// tcx_alu: instruction execute, alu ops and data memory address generation
// depends on tcx_pkg; purely combinational

module tcx_alu import tcx_pkg::*; (
  input  dec_t  dec,
  input  word_t opa,
  input  word_t opb,
  input  word_t opc,
  output res_t  res
);

  word_t off;
  word_t sum;

  always_comb begin
    off = (dec.op == OP_LDR || dec.op == OP_STR) ? opb : word_t'(dec.imm);
    sum = opa + off;
  end

  always_comb begin
    res = '0;
    if (dec.kind == KIND_PRELOAD) begin
      res.mem_wr   = 1'b1;
      res.mem_addr = dec.pre_addr;
      res.mem_data = dec.pre_data;
    end else begin
      unique case (dec.op) inside
        OP_LDR, OP_LDI: begin
          res.reg_wr   = 1'b1;
          res.reg_idx  = dec.rd;
          res.mem_rd   = 1'b1;
          res.mem_addr = sum[MEM_AW-1:0];
        end
        OP_STR, OP_STI: begin
          res.mem_wr   = 1'b1;
          res.mem_addr = sum[MEM_AW-1:0];
          res.mem_data = opc;
        end
        OP_AND: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = opa & opb;
        end
        OP_OR: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = opa | opb;
        end
        OP_ADD: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = opa + opb;
        end
        OP_ADDI: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = sum;
        end
        OP_SUB: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = opa - opb;
        end
        OP_SUBI: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = opa - word_t'(dec.imm);
        end
        OP_MOVI: begin
          res.reg_wr  = 1'b1;
          res.reg_idx = dec.rd;
          res.reg_val = word_t'(dec.movi);
        end
        default: begin
          res.illegal = 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: design/toy_cpu_execute_unit_top.sv
// toy_cpu_execute_unit_top: execute pipeline around register file and data memory
// depends on tcx_pkg, tcx_rf, tcx_dmem, tcx_alu

// Takes one item per cycle sustained while out_ready stays high. An accepted
// item first reads the register file, then executes and performs the data
// memory access, and its result then sits in the output register until
// taken. The register file is written back when the result beat
// is taken; younger instructions get the pending value by forwarding, so
// back-to-back dependent instructions, loads included, run without bubbles.
// There is no clearing pass after reset; the data memory holds undefined data
// until written by a preload or a store.

module toy_cpu_execute_unit_top import tcx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_instruction,
  input  logic [15:0] in_preload_address,
  input  logic [15:0] in_preload_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_written,
  output logic [2:0]  out_reg_index,
  output logic [15:0] out_reg_value,
  output logic        out_mem_written,
  output logic [15:0] out_mem_address,
  output logic [15:0] out_mem_data,
  output logic        out_illegal,
  output logic [15:0] out_executed_count
);

  dec_t   dec_in;
  logic   in_acc;
  logic   out_acc;
  logic   s1_go;
  logic   s2_free;

  logic   s1_v_r;
  logic   s1_fresh_r;
  dec_t   s1_dec_r;
  word_t  s1_a_r;
  word_t  s1_b_r;
  word_t  s1_c_r;

  logic   s2_v_r;
  res_t   s2_res_r;
  word_t  s2_pc_r;
  word_t  s2_wval;

  word_t  pc_r;
  word_t  pc_nxt;
  rf_wr_t lw_r;
  rf_wr_t rf_wr;

  word_t  rf_a;
  word_t  rf_b;
  word_t  rf_c;
  word_t  opa;
  word_t  opb;
  word_t  opc;
  res_t   alu_res;
  word_t  dm_rdata;

  function automatic word_t fwd_operand(
    input logic              fresh,
    input logic [RIDX_W-1:0] idx,
    input word_t             rf_val,
    input word_t             held,
    input rf_wr_t            lw,
    input logic              s2_wr,
    input logic [RIDX_W-1:0] s2_idx,
    input word_t             s2_val
  );
    word_t base;
    base = fresh ? ((lw.en && lw.idx == idx) ? lw.data : rf_val) : held;
    return (s2_wr && s2_idx == idx) ? s2_val : base;
  endfunction

  // decode
  always_comb begin
    dec_in.kind     = in_kind;
    dec_in.op       = in_instruction[15:12];
    dec_in.rd       = in_instruction[11:9];
    dec_in.rs       = in_instruction[8:6];
    dec_in.rt       = in_instruction[2:0];
    dec_in.imm      = in_instruction[5] ? in_instruction[4:0] : {2'b00, in_instruction[2:0]};
    dec_in.movi     = in_instruction[8:0];
    dec_in.pre_addr = in_preload_address[MEM_AW-1:0];
    dec_in.pre_data = in_preload_data;
  end

  assign s2_free  = !s2_v_r || out_ready;
  assign s1_go    = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = s2_v_r && out_ready;

  tcx_rf u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_s    (dec_in.rs),
    .rd_t    (dec_in.rt),
    .rd_d    (dec_in.rd),
    .rdata_s (rf_a),
    .rdata_t (rf_b),
    .rdata_d (rf_c),
    .wr      (rf_wr)
  );

  // operand forwarding from result stage and last writeback
  assign s2_wval = s2_res_r.mem_rd ? dm_rdata : s2_res_r.reg_val;

  always_comb begin
    opa = fwd_operand(s1_fresh_r, s1_dec_r.rs, rf_a, s1_a_r, lw_r,
                      s2_v_r && s2_res_r.reg_wr, s2_res_r.reg_idx, s2_wval);
    opb = fwd_operand(s1_fresh_r, s1_dec_r.rt, rf_b, s1_b_r, lw_r,
                      s2_v_r && s2_res_r.reg_wr, s2_res_r.reg_idx, s2_wval);
    opc = fwd_operand(s1_fresh_r, s1_dec_r.rd, rf_c, s1_c_r, lw_r,
                      s2_v_r && s2_res_r.reg_wr, s2_res_r.reg_idx, s2_wval);
  end

  tcx_alu u_alu (
    .dec (s1_dec_r),
    .opa (opa),
    .opb (opb),
    .opc (opc),
    .res (alu_res)
  );

  tcx_dmem u_dmem (
    .clk   (clk),
    .we    (s1_go && alu_res.mem_wr),
    .re    (s1_go && alu_res.mem_rd),
    .addr  (alu_res.mem_addr),
    .wdata (alu_res.mem_data),
    .rdata (dm_rdata)
  );

  assign pc_nxt = (s1_dec_r.kind == KIND_EXEC) ? pc_r + 16'd1 : pc_r;

  always_comb begin
    rf_wr.en   = out_acc && s2_res_r.reg_wr;
    rf_wr.idx  = s2_res_r.reg_idx;
    rf_wr.data = s2_wval;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_fresh_r <= 1'b0;
      s2_v_r     <= 1'b0;
      pc_r       <= '0;
      lw_r       <= '0;
    end else begin
      s1_fresh_r <= in_acc;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
        pc_r   <= pc_nxt;
      end else if (out_acc) begin
        s2_v_r <= 1'b0;
      end
      if (rf_wr.en) begin
        lw_r <= rf_wr;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dec_r <= dec_in;
    end
    if (s1_v_r) begin
      s1_a_r <= opa;
      s1_b_r <= opb;
      s1_c_r <= opc;
    end
    if (s1_go) begin
      s2_res_r <= alu_res;
      s2_pc_r  <= pc_nxt;
    end
  end

  assign out_valid          = s2_v_r;
  assign out_reg_written    = s2_res_r.reg_wr;
  assign out_reg_index      = s2_res_r.reg_idx;
  assign out_reg_value      = s2_wval;
  assign out_mem_written    = s2_res_r.mem_wr;
  assign out_mem_address    = s2_res_r.mem_wr ? word_t'(s2_res_r.mem_addr) : '0;
  assign out_mem_data       = s2_res_r.mem_data;
  assign out_illegal        = s2_res_r.illegal;
  assign out_executed_count = s2_pc_r;

  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reg_written && out_mem_written))
    else $error("result writes both register and memory");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> !out_reg_written && !out_mem_written)
    else $error("illegal instruction reports a write");

  a_load_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_ready |=> $stable(out_reg_value))
    else $error("result value changed while stalled");

  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_dec_r.kind == KIND_EXEC |=> pc_r == $past(pc_r) + 16'd1)
    else $error("program counter did not advance on execute");

endmodule

FILE: dv/testbench.sv
// testbench for toy_cpu_execute_unit_top: directed and random instruction streams
// checked beat by beat against an in-line model of registers, counter and memory
// depends on tcx_pkg and the design files only
`timescale 1ns / 1ps

module testbench;
  import tcx_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [OP_W-1:0] ILLEGAL_OPS [5] = '{4'd0, 4'd11, 4'd12, 4'd14, 4'd15};

  typedef struct packed {
    logic  kind;
    word_t instr;
    word_t pl_addr;
    word_t pl_data;
  } cpu_item_t;

  typedef struct packed {
    logic       reg_wr;
    logic [2:0] reg_idx;
    word_t      reg_val;
    logic       mem_wr;
    word_t      mem_addr;
    word_t      mem_data;
    logic       illegal;
    word_t      count;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [15:0] in_instruction;
  logic [15:0] in_preload_address;
  logic [15:0] in_preload_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_reg_written;
  logic [2:0]  out_reg_index;
  logic [15:0] out_reg_value;
  logic        out_mem_written;
  logic [15:0] out_mem_address;
  logic [15:0] out_mem_data;
  logic        out_illegal;
  logic [15:0] out_executed_count;

  word_t   arch_regs [NUM_REGS];
  word_t   arch_pc;
  word_t   data_mem [MEM_WORDS];
  bit      mem_known [MEM_WORDS];
  retire_t retire_queue [$];
  int      errors = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  int      cycles = 0;

  toy_cpu_execute_unit_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_instruction     (in_instruction),
    .in_preload_address (in_preload_address),
    .in_preload_data    (in_preload_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reg_written    (out_reg_written),
    .out_reg_index      (out_reg_index),
    .out_reg_value      (out_reg_value),
    .out_mem_written    (out_mem_written),
    .out_mem_address    (out_mem_address),
    .out_mem_data       (out_mem_data),
    .out_illegal        (out_illegal),
    .out_executed_count (out_executed_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [MEM_AW-1:0] effective_addr(word_t ins);
    word_t off;
    word_t sum;
    if (ins[15:12] == OP_LDR || ins[15:12] == OP_STR) off = arch_regs[ins[2:0]];
    else off = ins[5] ? word_t'(ins[4:0]) : word_t'(ins[2:0]);
    sum = arch_regs[ins[8:6]] + off;
    return sum[MEM_AW-1:0];
  endfunction

  function automatic retire_t execute_item(cpu_item_t it);
    retire_t r;
    logic [OP_W-1:0] op;
    word_t a, b, imm;
    logic [MEM_AW-1:0] addr;
    r = '0;
    if (it.kind == KIND_PRELOAD) begin
      addr = it.pl_addr[MEM_AW-1:0];
      r.mem_wr = 1'b1;
      r.mem_addr = word_t'(addr);
      r.mem_data = it.pl_data;
      data_mem[addr] = it.pl_data;
      mem_known[addr] = 1'b1;
    end else begin
      op = it.instr[15:12];
      a = arch_regs[it.instr[8:6]];
      b = arch_regs[it.instr[2:0]];
      imm = it.instr[5] ? word_t'(it.instr[4:0]) : word_t'(it.instr[2:0]);
      r.reg_idx = it.instr[11:9];
      r.reg_wr = 1'b1;
      case (op)
        OP_LDR, OP_LDI: r.reg_val = data_mem[effective_addr(it.instr)];
        OP_STR, OP_STI: begin
          addr = effective_addr(it.instr);
          r.reg_wr = 1'b0;
          r.mem_wr = 1'b1;
          r.mem_addr = word_t'(addr);
          r.mem_data = arch_regs[it.instr[11:9]];
          data_mem[addr] = r.mem_data;
          mem_known[addr] = 1'b1;
        end
        OP_AND:  r.reg_val = a & b;
        OP_OR:   r.reg_val = a | b;
        OP_ADD:  r.reg_val = a + b;
        OP_ADDI: r.reg_val = a + imm;
        OP_SUB:  r.reg_val = a - b;
        OP_SUBI: r.reg_val = a - imm;
        OP_MOVI: r.reg_val = word_t'(it.instr[8:0]);
        default: begin
          r.reg_wr = 1'b0;
          r.illegal = 1'b1;
        end
      endcase
      if (!r.reg_wr) r.reg_idx = '0;
      else arch_regs[r.reg_idx] = r.reg_val;
      arch_pc = arch_pc + 16'd1;
    end
    r.count = arch_pc;
    return r;
  endfunction

  task automatic send_item(cpu_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_kind <= 1'($urandom());
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_instruction <= it.instr;
    in_preload_address <= it.pl_addr;
    in_preload_data <= it.pl_data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    retire_queue.push_back(execute_item(it));
  endtask

  task automatic issue_preload(word_t addr, word_t data);
    cpu_item_t it;
    it.kind = KIND_PRELOAD;
    it.instr = word_t'($urandom());
    it.pl_addr = addr;
    it.pl_data = data;
    send_item(it);
  endtask

  // a load never reads a word that has not been written
  task automatic issue_instr(word_t ins);
    cpu_item_t it;
    logic [MEM_AW-1:0] addr;
    logic [3:0] page;
    if (ins[15:12] == OP_LDR || ins[15:12] == OP_LDI) begin
      addr = effective_addr(ins);
      if (!mem_known[addr]) begin
        page = 4'($urandom());
        issue_preload(word_t'({page, addr}), word_t'($urandom()));
      end
    end
    it.kind = KIND_EXEC;
    it.instr = ins;
    it.pl_addr = word_t'($urandom());
    it.pl_data = word_t'($urandom());
    send_item(it);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (retire_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic word_t enc(logic [3:0] op, logic [2:0] d, logic [2:0] s,
                                logic [5:0] low);
    return {op, d, s, low};
  endfunction

  task automatic test_directed;
    logic [11:0] low12;
    idle_pct = 0;
    stall_pct = 0;
    issue_preload(16'hFFFF, 16'hFFFF);
    issue_preload(16'h1000, 16'h0000);
    issue_instr(enc(OP_MOVI, 3'd1, 3'd7, 6'h3F));
    issue_instr(enc(OP_MOVI, 3'd7, 3'd0, 6'h01));
    issue_instr(enc(OP_SUBI, 3'd3, 3'd2, 6'b011001));
    issue_instr(enc(OP_ADD, 3'd4, 3'd3, 6'b000111));
    issue_instr(enc(OP_ADDI, 3'd5, 3'd3, 6'b111111));
    issue_instr(enc(OP_AND, 3'd6, 3'd3, 6'b100001));
    issue_instr(enc(OP_OR, 3'd6, 3'd1, 6'b000111));
    issue_instr(enc(OP_SUB, 3'd4, 3'd2, 6'b000011));
    issue_instr(enc(OP_STR, 3'd1, 3'd3, 6'b000111));
    issue_instr(enc(OP_STI, 3'd5, 3'd3, 6'b111111));
    issue_instr(enc(OP_LDR, 3'd0, 3'd3, 6'b000010));
    issue_instr(enc(OP_LDI, 3'd2, 3'd3, 6'b111111));
    issue_instr(enc(OP_LDI, 3'd4, 3'd3, 6'b011001));
    issue_instr(enc(OP_MOVI, 3'd0, 3'd0, 6'h00));
    for (int i = 0; i < 5; i++) begin
      low12 = (i == 0) ? 12'h000 : (i == 4) ? 12'hFFF : 12'($urandom());
      issue_instr({ILLEGAL_OPS[i], low12});
    end
    drain();
  endtask

  task automatic test_random(int count, int idle, int stall);
    int pick;
    logic [OP_W-1:0] op;
    logic [11:0] bits;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      pick = $urandom_range(99);
      bits = 12'($urandom());
      case ($urandom_range(6))
        0: op = OP_AND;
        1: op = OP_OR;
        2: op = OP_ADD;
        3: op = OP_ADDI;
        4: op = OP_SUB;
        5: op = OP_SUBI;
        default: op = OP_MOVI;
      endcase
      if (pick < 8) op = ILLEGAL_OPS[$urandom_range(4)];
      else if (pick < 20) op = OP_LDR;
      else if (pick < 32) op = OP_LDI;
      else if (pick < 42) op = OP_STR;
      else if (pick < 52) op = OP_STI;
      if (pick >= 90) issue_preload(word_t'($urandom()), word_t'($urandom()));
      else issue_instr({op, bits});
    end
    drain();
  endtask

  // receiver holds off long enough for the pipeline to fill and push back
  task automatic test_backpressure;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    test_random(60, 0, 0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_EXEC;
    in_instruction <= '0;
    in_preload_address <= '0;
    in_preload_data <= '0;
    arch_pc = '0;
    for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem_known[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(240, 0, 0);
    test_random(240, 68, 0);
    test_random(240, 0, 68);
    test_random(220, 13, 13);
    test_backpressure();
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void check_field(string name, word_t want, word_t got);
    if (want != got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  initial begin
    retire_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (retire_queue.size() == 0) begin
          $display("%0t: result beat with nothing pending", $time);
          errors++;
        end else begin
          want = retire_queue.pop_front();
          check_field("reg_written", word_t'(want.reg_wr), word_t'(out_reg_written));
          check_field("reg_index", word_t'(want.reg_idx), word_t'(out_reg_index));
          check_field("reg_value", want.reg_val, out_reg_value);
          check_field("mem_written", word_t'(want.mem_wr), word_t'(out_mem_written));
          check_field("mem_address", want.mem_addr, out_mem_address);
          check_field("mem_data", want.mem_data, out_mem_data);
          check_field("illegal", word_t'(want.illegal), word_t'(out_illegal));
          check_field("executed_count", want.count, out_executed_count);
        end
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

endmodule
